[design/frame_time_window_statistics_macros.svh]
// Assertion macros shared by the checker.
`ifndef FRAME_TIME_WINDOW_STATISTICS_MACROS_SVH
`define FRAME_TIME_WINDOW_STATISTICS_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define FTWS_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Condition holds in the cycle after the trigger.
`define FTWS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

[design/ftws_pkg.sv]
package ftws_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DUR_W   = 24;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned FPS_W   = 30;
  localparam int unsigned HELD_W  = 11;
  localparam int unsigned CFPS_W  = 10;
  localparam int unsigned PMC_W   = 11;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 24;
  localparam int unsigned DIV_W   = 32;

  localparam logic [DUR_W-1:0]  MIN_RESET   = 24'd1000000;
  localparam logic [DUR_W-1:0]  DROP_RESET  = 24'd11100;
  localparam logic [CFPS_W-1:0] CFPS_RESET  = 10'd90;
  localparam logic [PMC_W-1:0]  PMC_RESET   = 11'd100;
  localparam logic [DUR_W-1:0]  DUR_MAX     = 24'hFFFFFF;
  localparam logic [19:0]       US_PER_SEC  = 20'd1000000;

  // floor(n*99/100) as (n * PCT_RECIP) >> PCT_SHIFT, exact for n below 2^20
  localparam int unsigned       PCT_SHIFT   = 24;
  localparam logic [23:0]       PCT_RECIP   = 24'd16609444;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic [CIDX_W-1:0] REG_DROP_THRESHOLD = 2'd0;
  localparam logic [CIDX_W-1:0] REG_COMFORT_FPS    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PCT_MIN_COUNT  = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [DUR_W-1:0]  tot;
    logic [DUR_W-1:0]  cpu;
    logic [DUR_W-1:0]  gpu;
  } ring_entry_t;

  function automatic logic [DUR_W-1:0] diff24(input logic [TIME_W-1:0] later,
                                              input logic [TIME_W-1:0] earlier);
    logic [TIME_W-1:0] d;
    d = later - earlier;
    return (d > TIME_W'(DUR_MAX)) ? DUR_MAX : d[DUR_W-1:0];
  endfunction

  function automatic logic [DUR_W-1:0] sat24(input logic [DIV_W-1:0] q);
    return (q > DIV_W'(DUR_MAX)) ? DUR_MAX : q[DUR_W-1:0];
  endfunction

endpackage

[design/frame_time_window_statistics.sv]
// Channel | Direction | Handshake             | Payload
// in      | into      | in_valid / in_ready   | command, four timestamps
// out     | out of    | out_valid / out_ready | averages, min, max, p99, fps, counts
// cfg     | into      | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One transaction at a time. A record's run is set by the one-entry-per-step walk
// through the sorted-totals memory, which spans the held entries, and the whole
// window once it is full, and by four passes of the shared 32-step restoring
// divider; a clear skips the walk and goes straight to the divider passes.
// Reset is synchronous and active high; the stores need no clearing pass.
// A finished result waits in the output register without holding up input;
// the next result holds in the last step, with input closed, until it is taken.
module frame_time_window_statistics import ftws_pkg::*; #(
  parameter int unsigned WINDOW = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic [TIME_W-1:0]   frame_start_time,
  input  logic [TIME_W-1:0]   cpu_end_time,
  input  logic [TIME_W-1:0]   gpu_end_time,
  input  logic [TIME_W-1:0]   frame_end_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DUR_W-1:0]    avg_frame_us,
  output logic [DUR_W-1:0]    avg_cpu_us,
  output logic [DUR_W-1:0]    avg_gpu_us,
  output logic [DUR_W-1:0]    min_frame_us,
  output logic [DUR_W-1:0]    max_frame_us,
  output logic [DUR_W-1:0]    p99_frame_us,
  output logic [FPS_W-1:0]    frames_per_second,
  output logic [CNT_W-1:0]    dropped_count,
  output logic [CNT_W-1:0]    frame_count,
  output logic                comfortable,
  output logic [HELD_W-1:0]   samples_held,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CDATA_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned OW = CW + 1;
  localparam int unsigned PW = CW + PCT_SHIFT;
  localparam logic [AW-1:0] LAST_POS = AW'(WINDOW - 1);
  localparam logic [CW-1:0] FULL     = CW'(WINDOW);
  localparam logic [4:0]    DIV_LAST = 5'(DIV_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_OLD_RD, ST_OLD, ST_RM_RD, ST_RM_CHK, ST_INS_RD, ST_INS_CHK,
    ST_INS_LAST, ST_COMMIT, ST_SPAN_RD, ST_SPAN, ST_DIV_LOAD, ST_DIV_RUN,
    ST_P99_RD, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_TOT, OP_CPU, OP_GPU, OP_FPS
  } div_op_t;

  state_t             state;
  div_op_t            op;

  // Configuration
  logic [DUR_W-1:0]   drop_thr;
  logic [CFPS_W-1:0]  comfort_fps;
  logic [PMC_W-1:0]   pct_min;

  // Latched transaction
  logic               cmd_clear;
  logic [TIME_W-1:0]  ts;
  logic [DUR_W-1:0]   tot_new;
  logic [DUR_W-1:0]   cpu_new;
  logic [DUR_W-1:0]   gpu_new;

  // Statistics
  logic [AW-1:0]      wp;
  logic [CW-1:0]      held;
  logic [SUM_W-1:0]   sum_tot;
  logic [SUM_W-1:0]   sum_cpu;
  logic [SUM_W-1:0]   sum_gpu;
  logic [DUR_W-1:0]   min_tot;
  logic [DUR_W-1:0]   max_tot;
  logic [CNT_W-1:0]   drop_cnt;
  logic [CNT_W-1:0]   frame_cnt;

  // Sorted-list walk
  logic [AW-1:0]      pos;
  logic               found;
  logic [DUR_W-1:0]   rm_val;
  logic [TIME_W-1:0]  span;
  logic [PW-1:0]      idx_prod;

  // Divider and its results
  logic [DIV_W:0]     div_rem;
  logic [DIV_W-1:0]   div_q;
  logic [DIV_W-1:0]   div_d;
  logic [4:0]         div_cnt;
  logic [DIV_W:0]     div_shift;
  logic [DIV_W:0]     div_rem_next;
  logic [DIV_W-1:0]   div_q_next;
  logic [DIV_W-1:0]   dividend;
  logic [DIV_W-1:0]   divisor;
  logic [DUR_W-1:0]   avg_tot;
  logic [DUR_W-1:0]   avg_cpu;
  logic [DUR_W-1:0]   avg_gpu;
  logic [FPS_W-1:0]   fps;

  // Memories
  ring_entry_t        ring_mem [WINDOW];
  ring_entry_t        ring_rdata;
  ring_entry_t        ring_wdata;
  logic               ring_we;
  logic [AW-1:0]      ring_raddr;
  logic [DUR_W-1:0]   sort_mem [WINDOW];
  logic [DUR_W-1:0]   sort_rdata;
  logic [DUR_W-1:0]   sort_wdata;
  logic [AW-1:0]      sort_waddr;
  logic               sort_we;

  logic [OW-1:0]      wp_ext;
  logic [OW-1:0]      held_ext;
  logic [OW-1:0]      oldest_full;
  logic               fps_ok;
  logic               pct_ok;
  logic               load_out;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Oldest slot in the window: wp - held, wrapped
  assign wp_ext      = OW'(wp);
  assign held_ext    = OW'(held);
  assign oldest_full = (wp_ext >= held_ext) ? (wp_ext - held_ext)
                                            : (wp_ext + OW'(WINDOW) - held_ext);

  assign ring_raddr = (state == ST_OLD_RD) ? wp : oldest_full[AW-1:0];
  assign ring_we    = (state == ST_COMMIT);
  assign ring_wdata = '{start: ts, tot: tot_new, cpu: cpu_new, gpu: gpu_new};

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp] <= ring_wdata;
    end
    ring_rdata <= ring_mem[ring_raddr];
  end

  // Sorted list: shift down after the removed value, shift up ahead of the insert
  always_comb begin
    sort_we    = 1'b0;
    sort_waddr = pos;
    sort_wdata = tot_new;
    unique case (state)
      ST_RM_CHK: begin
        sort_we    = found;
        sort_waddr = pos - AW'(1);
        sort_wdata = sort_rdata;
      end
      ST_INS_CHK: begin
        sort_we    = 1'b1;
        sort_waddr = pos + AW'(1);
        sort_wdata = (sort_rdata > tot_new) ? sort_rdata : tot_new;
      end
      ST_INS_LAST: begin
        sort_we    = 1'b1;
        sort_waddr = '0;
      end
      default: begin
        sort_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sort_we) begin
      sort_mem[sort_waddr] <= sort_wdata;
    end
    sort_rdata <= sort_mem[pos];
  end

  // Divider operands
  always_comb begin
    dividend = sum_tot;
    divisor  = DIV_W'(held);
    unique case (op)
      OP_TOT: dividend = sum_tot;
      OP_CPU: dividend = sum_cpu;
      OP_GPU: dividend = sum_gpu;
      OP_FPS: begin
        dividend = DIV_W'(held - CW'(1)) * DIV_W'(US_PER_SEC);
        divisor  = span;
      end
      default: dividend = sum_tot;
    endcase
  end

  // One restoring step
  assign div_shift    = {div_rem[DIV_W-1:0], div_q[DIV_W-1]};
  assign div_rem_next = (div_shift >= {1'b0, div_d}) ? (div_shift - {1'b0, div_d})
                                                     : div_shift;
  assign div_q_next   = {div_q[DIV_W-2:0], (div_shift >= {1'b0, div_d})};

  // Percentile rank: 99/100 of the held count by a scaled reciprocal
  assign idx_prod = PW'(held) * PW'(PCT_RECIP);

  assign fps_ok   = (held >= CW'(2)) && (span != '0);
  assign pct_ok   = (held != '0) && (PMC_W'(held) >= pct_min);
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      op          <= OP_TOT;
      out_valid   <= 1'b0;
      drop_thr    <= DROP_RESET;
      comfort_fps <= CFPS_RESET;
      pct_min     <= PMC_RESET;
      wp          <= '0;
      held        <= '0;
      sum_tot     <= '0;
      sum_cpu     <= '0;
      sum_gpu     <= '0;
      min_tot     <= MIN_RESET;
      max_tot     <= '0;
      drop_cnt    <= '0;
      frame_cnt   <= '0;
      pos         <= '0;
      found       <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_DROP_THRESHOLD: drop_thr    <= cfg_data[DUR_W-1:0];
          REG_COMFORT_FPS:    comfort_fps <= cfg_data[CFPS_W-1:0];
          REG_PCT_MIN_COUNT:  pct_min     <= cfg_data[PMC_W-1:0];
          default:            ;
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_clear <= (command == CMD_CLEAR);
            ts        <= frame_start_time;
            cpu_new   <= diff24(cpu_end_time, frame_start_time);
            gpu_new   <= diff24(gpu_end_time, cpu_end_time);
            tot_new   <= diff24(frame_end_time, frame_start_time);
            if (command == CMD_CLEAR) begin
              // restore every statistic; register values stay
              wp        <= '0;
              held      <= '0;
              sum_tot   <= '0;
              sum_cpu   <= '0;
              sum_gpu   <= '0;
              min_tot   <= MIN_RESET;
              max_tot   <= '0;
              drop_cnt  <= '0;
              frame_cnt <= '0;
              op        <= OP_TOT;
              state     <= ST_DIV_LOAD;
            end else begin
              if (frame_cnt != '1) begin
                frame_cnt <= frame_cnt + CNT_W'(1);
              end
              if (held == FULL) begin
                state <= ST_OLD_RD;
              end else if (held == '0) begin
                state <= ST_INS_LAST;
              end else begin
                pos   <= AW'(held - CW'(1));
                state <= ST_INS_RD;
              end
            end
          end
        end
        ST_OLD_RD: begin
          state <= ST_OLD;
        end
        ST_OLD: begin
          // drop the oldest frame from the sums, then hunt it in the sorted list
          sum_tot <= sum_tot - SUM_W'(ring_rdata.tot);
          sum_cpu <= sum_cpu - SUM_W'(ring_rdata.cpu);
          sum_gpu <= sum_gpu - SUM_W'(ring_rdata.gpu);
          rm_val  <= ring_rdata.tot;
          pos     <= '0;
          found   <= 1'b0;
          state   <= ST_RM_RD;
        end
        ST_RM_RD: begin
          state <= ST_RM_CHK;
        end
        ST_RM_CHK: begin
          if (!found && (sort_rdata == rm_val)) begin
            found <= 1'b1;
          end
          if (pos == LAST_POS) begin
            held  <= CW'(WINDOW - 1);
            pos   <= AW'(WINDOW - 2);
            state <= ST_INS_RD;
          end else begin
            pos   <= pos + AW'(1);
            state <= ST_RM_RD;
          end
        end
        ST_INS_RD: begin
          state <= ST_INS_CHK;
        end
        ST_INS_CHK: begin
          // larger entries move up; stop above the first entry not larger
          if (sort_rdata > tot_new) begin
            if (pos == '0) begin
              state <= ST_INS_LAST;
            end else begin
              pos   <= pos - AW'(1);
              state <= ST_INS_RD;
            end
          end else begin
            state <= ST_COMMIT;
          end
        end
        ST_INS_LAST: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          sum_tot <= sum_tot + SUM_W'(tot_new);
          sum_cpu <= sum_cpu + SUM_W'(cpu_new);
          sum_gpu <= sum_gpu + SUM_W'(gpu_new);
          held    <= held + CW'(1);
          wp      <= (wp == LAST_POS) ? '0 : wp + AW'(1);
          if (tot_new < min_tot) begin
            min_tot <= tot_new;
          end
          if (tot_new > max_tot) begin
            max_tot <= tot_new;
          end
          if ((tot_new > drop_thr) && (drop_cnt != '1)) begin
            drop_cnt <= drop_cnt + CNT_W'(1);
          end
          state <= ST_SPAN_RD;
        end
        ST_SPAN_RD: begin
          state <= ST_SPAN;
        end
        ST_SPAN: begin
          // newest start is the one just recorded
          span  <= ts - ring_rdata.start;
          op    <= OP_TOT;
          state <= ST_DIV_LOAD;
        end
        ST_DIV_LOAD: begin
          div_rem <= '0;
          div_q   <= dividend;
          div_d   <= divisor;
          div_cnt <= '0;
          state   <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          div_rem <= div_rem_next;
          div_q   <= div_q_next;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == DIV_LAST) begin
            unique case (op)
              OP_TOT: begin
                avg_tot <= (held == '0) ? '0 : sat24(div_q_next);
                op      <= OP_CPU;
                state   <= ST_DIV_LOAD;
              end
              OP_CPU: begin
                avg_cpu <= (held == '0) ? '0 : sat24(div_q_next);
                op      <= OP_GPU;
                state   <= ST_DIV_LOAD;
              end
              OP_GPU: begin
                avg_gpu <= (held == '0) ? '0 : sat24(div_q_next);
                op      <= OP_FPS;
                state   <= ST_DIV_LOAD;
              end
              OP_FPS: begin
                fps   <= (fps_ok && !cmd_clear) ? div_q_next[FPS_W-1:0] : '0;
                pos   <= idx_prod[PCT_SHIFT +: AW];
                state <= ST_P99_RD;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_P99_RD: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            avg_frame_us      <= avg_tot;
            avg_cpu_us        <= avg_cpu;
            avg_gpu_us        <= avg_gpu;
            min_frame_us      <= min_tot;
            max_frame_us      <= max_tot;
            p99_frame_us      <= pct_ok ? sort_rdata : max_tot;
            frames_per_second <= fps;
            dropped_count     <= drop_cnt;
            frame_count       <= frame_cnt;
            comfortable       <= (fps >= FPS_W'(comfort_fps));
            samples_held      <= HELD_W'(held);
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/ftws_checker.sv]
`include "frame_time_window_statistics_macros.svh"

module ftws_checker import ftws_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DUR_W-1:0]   avg_frame_us,
  input logic [DUR_W-1:0]   avg_cpu_us,
  input logic [FPS_W-1:0]   frames_per_second,
  input logic [CNT_W-1:0]   frame_count,
  input logic [HELD_W-1:0]  samples_held
);

  // one transaction in flight: input closes straight after acceptance
  `FTWS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")

  // a stalled result holds
  `FTWS_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(frame_count) && $stable(avg_frame_us), "result changed under stall")

  // the window never holds more frames than were recorded
  `FTWS_ASSERT_SAME(a_held_le_count, out_valid, HELD_W'(samples_held) <= frame_count || frame_count == '1, "window larger than frame count")

  // an empty window reports zero averages and rate
  `FTWS_ASSERT_SAME(a_empty_zero, out_valid && samples_held == '0, avg_frame_us == '0 && avg_cpu_us == '0 && frames_per_second == '0, "empty window not zero")

endmodule

bind frame_time_window_statistics ftws_checker u_ftws_checker (.*);
